>>> design/bdq_pkg.sv
// shared constants for the bounded deque with positional insert and remove
`default_nettype none

package bdq_pkg;

  localparam int DefDepth = 16;

  localparam int KindW   = 3;
  localparam int ValueW  = 32;
  localparam int PosW    = 4;
  localparam int StatusW = 2;

  // operation codes
  localparam logic [KindW-1:0] KindPushTail = 3'd0;
  localparam logic [KindW-1:0] KindPushHead = 3'd1;
  localparam logic [KindW-1:0] KindPopHead  = 3'd2;
  localparam logic [KindW-1:0] KindPopTail  = 3'd3;
  localparam logic [KindW-1:0] KindInsertAt = 3'd4;
  localparam logic [KindW-1:0] KindRemoveAt = 3'd5;

  // result status codes
  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

endpackage

`default_nettype wire

>>> design/bounded_deque_positional_core.sv
// top level: bounded deque with positional insert and remove, shifted one entry per cycle
//
//  channel   ports                                   direction  transfer when
//  command   start_i kind_i value_i position_i       in         start_i && !busy_o
//  result    done_o status_o removed_value_o count_o out        done_o (one cycle)
//
// steps: an error or unknown kind answers in the cycle after the transfer. a push or
// insert runs S_SHIFT to move entries up from the insert index, then S_WRITE; a pop or
// remove runs S_READ, S_GRAB, then S_SHIFT to close the gap. The entry memory moves one
// entry per cycle (read of the source overlaps the write of the previous destination).
// reset: count clears, the entry memory is left as is and is never read before written.
// stalls: busy_o stays high until the result cycle; the receiver cannot stall results.
`default_nettype none

module bounded_deque_positional_core #(
  parameter int DEPTH = bdq_pkg::DefDepth
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic [bdq_pkg::KindW-1:0]             kind_i,
  input  wire logic signed [bdq_pkg::ValueW-1:0]     value_i,
  input  wire logic [bdq_pkg::PosW-1:0]              position_i,
  output logic                                       busy_o,
  output logic                                       done_o,
  output logic [bdq_pkg::StatusW-1:0]                status_o,
  output logic signed [bdq_pkg::ValueW-1:0]          removed_value_o,
  output logic [$clog2(DEPTH+1)-1:0]                 count_o
);
  import bdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // compare width for position against the last index
  localparam int XW = (CW > PosW) ? CW : PosW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,   // remove: fetch the entry being taken out
    S_GRAB,   // remove: capture it
    S_SHIFT,  // move entries one per cycle
    S_WRITE   // insert: drop the new value into the gap
  } state_e;

  state_e state_q;

  // entry memory, one write and one registered read per cycle
  logic signed [ValueW-1:0] mem_q [DEPTH];
  logic signed [ValueW-1:0] rd_data_q;
  logic [AW-1:0]            rd_addr;
  logic                     mem_we;
  logic [AW-1:0]            mem_wa;
  logic signed [ValueW-1:0] mem_wd;

  // sequencer state
  logic [CW-1:0]            count_q;
  logic [AW-1:0]            ptr_q;       // next destination to move into
  logic [AW-1:0]            end_q;       // destination that ends the move
  logic                     up_q;        // 1: open a gap (insert), 0: close one (remove)
  logic                     pend_q;      // a read is in flight, write it next cycle
  logic [AW-1:0]            pend_addr_q;
  logic signed [ValueW-1:0] value_q;
  logic                     done_q;
  logic [StatusW-1:0]       status_q;
  logic signed [ValueW-1:0] removed_q;

  // decode of the incoming command
  logic          is_push;
  logic          is_pop;
  logic          is_full;
  logic          is_empty;
  logic [AW-1:0] last_idx;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] last_x;
  logic [AW-1:0] clamp_idx;
  logic [AW-1:0] ins_idx;
  logic [AW-1:0] rem_idx;

  always_comb begin
    is_push  = (kind_i == KindPushTail) || (kind_i == KindPushHead) ||
               (kind_i == KindInsertAt);
    is_pop   = (kind_i == KindPopHead) || (kind_i == KindPopTail) ||
               (kind_i == KindRemoveAt);
    is_full  = (count_q == CW'(DEPTH));
    is_empty = (count_q == '0);
    last_idx = AW'(count_q - CW'(1));
    pos_x    = XW'(position_i);
    last_x   = XW'(last_idx);
    // min(position, count-1)
    clamp_idx = (pos_x < last_x) ? AW'(pos_x) : last_idx;

    priority if (kind_i == KindPushTail) begin
      ins_idx = AW'(count_q);
    end else if ((kind_i == KindPushHead) || is_empty || (position_i == '0)) begin
      ins_idx = '0;
    end else begin
      ins_idx = clamp_idx + AW'(1);
    end

    priority if (kind_i == KindPopHead) begin
      rem_idx = '0;
    end else if (kind_i == KindPopTail) begin
      rem_idx = last_idx;
    end else begin
      rem_idx = clamp_idx;
    end
  end

  // memory port control
  always_comb begin
    rd_addr = ptr_q;
    mem_we  = 1'b0;
    mem_wa  = pend_addr_q;
    mem_wd  = rd_data_q;
    unique case (state_q)
      S_SHIFT: begin
        mem_we = pend_q;
        if (ptr_q != end_q) begin
          rd_addr = up_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
        end
      end
      S_WRITE: begin
        mem_we = 1'b1;
        mem_wa = ptr_q;
        mem_wd = value_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      end_q       <= '0;
      up_q        <= 1'b0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      value_q     <= '0;
      done_q      <= 1'b0;
      status_q    <= StOk;
      removed_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            pend_q <= 1'b0;
            priority if (is_push && is_full) begin
              done_q    <= 1'b1;
              status_q  <= StFull;
              removed_q <= '0;
            end else if (is_pop && is_empty) begin
              done_q    <= 1'b1;
              status_q  <= StEmpty;
              removed_q <= '0;
            end else if (is_push) begin
              // open a gap from the tail down to the insert index
              ptr_q   <= AW'(count_q);
              end_q   <= ins_idx;
              up_q    <= 1'b1;
              value_q <= value_i;
              state_q <= S_SHIFT;
            end else if (is_pop) begin
              ptr_q   <= rem_idx;
              end_q   <= last_idx;
              up_q    <= 1'b0;
              state_q <= S_READ;
            end else begin
              // unknown kind: nothing changes
              done_q    <= 1'b1;
              status_q  <= StOk;
              removed_q <= '0;
            end
          end
        end
        S_READ: begin
          state_q <= S_GRAB;
        end
        S_GRAB: begin
          removed_q <= rd_data_q;
          state_q   <= S_SHIFT;
        end
        S_SHIFT: begin
          if (ptr_q != end_q) begin
            pend_q      <= 1'b1;
            pend_addr_q <= ptr_q;
            ptr_q       <= up_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
          end else begin
            pend_q <= 1'b0;
            if (up_q) begin
              state_q <= S_WRITE;
            end else begin
              // gap closed: report the removal
              count_q  <= count_q - CW'(1);
              done_q   <= 1'b1;
              status_q <= StOk;
              state_q  <= S_IDLE;
            end
          end
        end
        S_WRITE: begin
          count_q   <= count_q + CW'(1);
          done_q    <= 1'b1;
          status_q  <= StOk;
          removed_q <= '0;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign count_o         = count_q;

endmodule

`default_nettype wire

>>> design/bdq_checker.sv
// port-level checks for the bounded deque, bound to the top level
`default_nettype none

module bdq_checker #(
  parameter int DEPTH = bdq_pkg::DefDepth
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start_i,
  input wire logic                              busy_o,
  input wire logic                              done_o,
  input wire logic [bdq_pkg::StatusW-1:0]       status_o,
  input wire logic signed [bdq_pkg::ValueW-1:0] removed_value_o,
  input wire logic [$clog2(DEPTH+1)-1:0]        count_o
);
  import bdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // every accepted command is either answered at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted command neither answered nor busy");

  // an empty error leaves nothing stored and removes nothing
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == StEmpty)) |-> ((count_o == '0) && (removed_value_o == '0)))
    else $error("empty error with nonzero count or value");

  // a full error reports the full count
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == StFull)) |-> ((count_o == CW'(DEPTH)) &&
                                          (removed_value_o == '0)))
    else $error("full error without a full store");

  // the count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_o <= CW'(DEPTH))
    else $error("count above capacity");

  // no result while a command is still being worked on
  a_no_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

endmodule

bind bounded_deque_positional_core bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);

`default_nettype wire
